// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the affine warp coefficient generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AWCG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");
`define AWCG_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define AWCG_ASSERT(lbl, clk, rstn, prop)
`define AWCG_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== sv/awcg_pkg.sv =====
// Shared types, constants and helpers of the affine warp coefficient generator.
package awcg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DIV_QBITS     = 31;
  localparam int DIV_LAT       = DIV_QBITS + 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESSIVE  = 2'd2;

  localparam logic [15:0] WIDTH_SD   = 16'd720;
  localparam logic [15:0] HEIGHT_PAL = 16'd288;

  localparam logic [1:0] GEOM_PAL    = 2'd0;
  localparam logic [1:0] GEOM_NTSC   = 2'd1;
  localparam logic [1:0] GEOM_SQUARE = 2'd2;
  localparam logic [1:0] GEOM_FIELD  = 2'd3;

  typedef struct packed {
    logic [3:0] yx_num;
    logic [3:0] yx_den;
    logic [3:0] xy_num;
    logic [3:0] xy_den;
  } ratio_t;

  typedef struct packed {
    logic               ident;
    logic [1:0]         geom;
    logic signed [31:0] angle;
    logic signed [31:0] offset_x;
    logic signed [31:0] origin_y;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic ratio_t geom_ratio(input logic [1:0] g);
    ratio_t r;
    unique case (g)
      GEOM_PAL:    r = '{yx_num: 4'd8, yx_den: 4'd15, xy_num: 4'd15, xy_den: 4'd8};
      GEOM_NTSC:   r = '{yx_num: 4'd4, yx_den: 4'd9,  xy_num: 4'd9,  xy_den: 4'd4};
      GEOM_SQUARE: r = '{yx_num: 4'd1, yx_den: 4'd1,  xy_num: 4'd1,  xy_den: 4'd1};
      default:     r = '{yx_num: 4'd1, yx_den: 4'd2,  xy_num: 4'd2,  xy_den: 4'd1};
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/awcg_if.sv =====
// Input and result channel interfaces of the affine warp coefficient generator.
interface awcg_in_if;
  logic               valid;
  logic               ready;
  logic               compensate;
  logic signed [31:0] angle;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic [31:0]        scale_x;
  logic [31:0]        scale_y;

  modport source(output valid, compensate, angle, offset_x, offset_y, scale_x, scale_y,
                 input ready);
  modport sink(input valid, compensate, angle, offset_x, offset_y, scale_x, scale_y,
               output ready);
endinterface

interface awcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] xx_step;
  logic signed [31:0] xy_step;
  logic signed [31:0] yx_step;
  logic signed [31:0] yy_step;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;

  modport source(output valid, xx_step, xy_step, yx_step, yy_step, origin_x, origin_y,
                 input ready);
  modport sink(input valid, xx_step, xy_step, yx_step, yy_step, origin_x, origin_y,
               output ready);
endinterface

// ===== sv/affine_warp_coefficient_gen.sv =====
// Affine warp coefficient generator: config registers, front end, queue, back end.
// Throughput: one parameter set per cycle while the output is not stalled; the back end
// pipeline advances whenever its output register is empty or being taken, and the divider
// gives one quotient bit a stage.
// Reset: synchronous active-low rst_n clears all valid state and loads the geometry
// registers with width 720, height 288 and interlaced mode.
`include "assert_macros.svh"

module affine_warp_coefficient_gen #(
  parameter int FRAC_BITS = awcg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  awcg_in_if.sink                         in_chan,
  awcg_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [awcg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [awcg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import awcg_pkg::*;

  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        prog_r;
  cmd_t        push_data;
  logic        push_valid;
  logic        push_ready;
  cmd_t        pop_data;
  logic        pop_valid;
  logic        pop_ready;
  fifo_stat_t  fstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_SD;
      height_r <= HEIGHT_PAL;
      prog_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: height_r <= cfg_data;
        CFG_PROGRESSIVE:  prog_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  awcg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .frame_width (width_r),
    .frame_height(height_r),
    .progressive (prog_r),
    .cmd         (push_data),
    .cmd_valid   (push_valid),
    .cmd_ready   (push_ready)
  );

  awcg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .stat      (fstat)
  );

  awcg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (pop_data),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .out_chan (out_chan)
  );

  `AWCG_ASSERT(a_queue_state, clk, rst_n, !(fstat.full && fstat.empty))
  `AWCG_ASSERT(a_front_holds, clk, rst_n, !in_chan.ready |-> push_valid)
  `AWCG_ASSERT_NORST(a_reset_quiet, clk, !rst_n |=> !out_chan.valid)

endmodule

// ===== sv/awcg_front.sv =====
// Front end: accepts parameter sets, clamps the angle and classifies geometry.
module awcg_front #(
  parameter int FRAC_BITS = awcg_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  awcg_in_if.sink        in_chan,
  input  logic [15:0]    frame_width,
  input  logic [15:0]    frame_height,
  input  logic           progressive,
  output awcg_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);
  import awcg_pkg::*;

  localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
  localparam longint LIM_I = ONE / 2;
  localparam longint LIM_P = (8 * ONE + 10) / 20;

  logic               v_r;
  cmd_t               cmd_r;
  cmd_t               cmd_nxt;
  logic signed [31:0] lim;
  logic signed [31:0] a_clamp;
  logic signed [32:0] oy_inc;

  assign in_chan.ready = !v_r || cmd_ready;
  assign cmd           = cmd_r;
  assign cmd_valid     = v_r;

  always_comb begin
    lim = progressive ? 32'(LIM_P) : 32'(LIM_I);
    if (in_chan.angle > lim) begin
      a_clamp = lim;
    end else if (in_chan.angle < -lim) begin
      a_clamp = -lim;
    end else begin
      a_clamp = in_chan.angle;
    end
    oy_inc = 33'(in_chan.offset_y) + 33'sd1;

    cmd_nxt.ident    = !in_chan.compensate;
    cmd_nxt.angle    = a_clamp;
    cmd_nxt.offset_x = in_chan.compensate ? in_chan.offset_x : '0;
    if (!in_chan.compensate) begin
      cmd_nxt.origin_y = '0;
    end else if (progressive) begin
      cmd_nxt.origin_y = in_chan.offset_y;
    end else begin
      cmd_nxt.origin_y = oy_inc[32:1];
    end
    cmd_nxt.scale_x = in_chan.scale_x;
    cmd_nxt.scale_y = in_chan.scale_y;
    if (frame_width == WIDTH_SD) begin
      cmd_nxt.geom = (frame_height == HEIGHT_PAL) ? GEOM_PAL : GEOM_NTSC;
    end else begin
      cmd_nxt.geom = progressive ? GEOM_SQUARE : GEOM_FIELD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_chan.ready) begin
      v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== sv/awcg_fifo.sv =====
// Short queue between front end and arithmetic back end.
module awcg_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  awcg_pkg::cmd_t       push_data,
  input  logic                 push_valid,
  output logic                 push_ready,
  output awcg_pkg::cmd_t       pop_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output awcg_pkg::fifo_stat_t stat
);
  import awcg_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            entry_r [DEPTH];
  logic [PTRW-1:0] wp_r;
  logic [PTRW-1:0] rp_r;
  logic [PTRW:0]   cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != (PTRW+1)'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = entry_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTRW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTRW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/awcg_div.sv =====
// Pipelined restoring divider for the saturating aspect zoom, one quotient bit per stage.
module awcg_div #(
  parameter int FRAC_BITS = awcg_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [3:0]         num,
  input  logic [3:0]         den,
  input  logic [31:0]        zoom,
  output logic signed [31:0] quo
);
  import awcg_pkg::*;

  localparam int QB  = DIV_QBITS;
  localparam int DZW = 36;
  localparam int DW  = DZW + 1;
  localparam int NW  = (2 * FRAC_BITS + 6 > DW + 1) ? 2 * FRAC_BITS + 6 : DW + 1;
  localparam int CW  = DW + QB;

  logic [DZW-1:0] dz_r;
  logic [3:0]     num_r;
  logic [NW-1:0]  rem_r [0:QB];
  logic [DW-1:0]  d_r   [0:QB];
  logic [QB-1:0]  q_r   [0:QB];
  logic           sat_r [0:QB];
  logic [NW-1:0]  nn;
  logic [DW-1:0]  dd;
  logic           sat_c;

  assign nn    = (NW'(num_r) << (2 * FRAC_BITS + 1)) + NW'(dz_r);
  assign dd    = {dz_r, 1'b0};
  assign sat_c = (dz_r == '0) || (CW'(nn) >= (CW'(dd) << QB));

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r     <= DZW'(den) * DZW'(zoom);
      num_r    <= num;
      rem_r[0] <= nn;
      d_r[0]   <= dd;
      q_r[0]   <= '0;
      sat_r[0] <= sat_c;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int SH = QB - j;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(d_r[j-1]) << SH;
    assign ge    = CW'(rem_r[j-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? NW'(CW'(rem_r[j-1]) - trial) : rem_r[j-1];
        q_r[j]   <= {q_r[j-1][QB-2:0], ge};
        d_r[j]   <= d_r[j-1];
        sat_r[j] <= sat_r[j-1];
      end
    end
  end

  assign quo = sat_r[QB] ? 32'sh7fffffff : $signed({1'b0, q_r[QB]});

endmodule

// ===== sv/awcg_back.sv =====
// Back end: Taylor sine/cosine, zoom products and cross terms in one stall pipeline.
module awcg_back #(
  parameter int FRAC_BITS = awcg_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  awcg_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  awcg_out_if.source     out_chan
);
  import awcg_pkg::*;

  localparam int     F     = FRAC_BITS;
  localparam int     AW    = F + 2;
  localparam int     PW    = 2 * AW;
  localparam int     UW    = F + 4;
  localparam int     K3    = F + 6;
  localparam int     K5    = F + 7;
  localparam int     DL    = DIV_LAT;
  localparam int     DEPTH = DL + 2;
  localparam longint ONE   = 64'sd1 <<< F;

  localparam logic [K3:0]          M3    = (K3+1)'(((64'd1 << K3) + 64'd2) / 64'd3);
  localparam logic [K5:0]          M5    = (K5+1)'(((64'd1 << K5) + 64'd4) / 64'd5);
  localparam logic signed [AW-1:0] ONE_A = AW'(ONE);
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE);
  localparam logic signed [PW-1:0] ONE2  = PW'(2 * ONE);
  localparam logic signed [PW-1:0] ONE3  = PW'(3 * ONE);
  localparam logic signed [PW-1:0] ONE5  = PW'(5 * ONE);
  localparam logic signed [AW+32:0] HALFX = (AW+33)'(ONE / 2);
  localparam logic signed [31:0]   ONE_O = 32'(ONE);

  typedef struct packed {
    logic               ident;
    logic signed [31:0] offset_x;
    logic signed [31:0] origin_y;
  } ctl_t;

  logic                   en;
  logic [DEPTH:1]         v_r;
  ctl_t                   ctl_r [1:DEPTH];
  logic signed [AW-1:0]   a_r   [1:7];
  logic [31:0]            zx_r  [1:10];
  logic [31:0]            zy_r  [1:10];
  logic signed [AW-1:0]   c_r   [2:10];
  logic signed [AW-1:0]   s_r   [5:DL];
  logic signed [31:0]     xx_r  [12:DEPTH-1];
  logic signed [31:0]     yy_r  [12:DEPTH-1];
  logic signed [PW-1:0]   sq_r, p3_r, p6_r, p8_r;
  logic signed [AW-1:0]   n1_r, n2_r, n3_r;
  logic [UW+K3:0]         m4_r;
  logic [UW+K5:0]         m9_r;
  logic signed [AW+32:0]  xxp_r, yyp_r;
  logic signed [AW+31:0]  xyp_r, yxp_r;
  logic signed [31:0]     xx_o_r, xy_o_r, yx_o_r, yy_o_r, ox_o_r, oy_o_r;

  logic signed [AW-1:0]   a_in;
  logic signed [PW-1:0]   n1_w, y4, n3_w, y9;
  logic [UW-1:0]          u4, u9;
  logic signed [AW-1:0]   n2_w, n4_w;
  logic signed [AW+32:0]  xxh, yyh;
  logic signed [AW+31:0]  xyh, yxh;
  logic signed [31:0]     xyz, yxz;
  ratio_t                 rt;

  assign en        = !v_r[DEPTH] || out_chan.ready;
  assign cmd_ready = en;
  assign a_in      = cmd.angle[AW-1:0];
  assign rt        = geom_ratio(cmd.geom);

  assign n1_w = (sq_r + ONE_P) >>> (F + 1);
  assign y4   = ((p3_r <<< 1) + ONE3) >>> (F + 1);
  assign u4   = UW'(y4 + ONE_P * PW'(3));
  assign n2_w = $signed(m4_r[K3 +: AW]) - ONE_A;
  assign n3_w = (p6_r + ONE2) >>> (F + 2);
  assign y9   = ((p8_r <<< 1) + ONE5) >>> (F + 1);
  assign u9   = UW'(y9 + ONE5);
  assign n4_w = $signed(m9_r[K5 +: AW]) - ONE_A;
  assign xxh  = (xxp_r + HALFX) >>> F;
  assign yyh  = (yyp_r + HALFX) >>> F;
  assign xyh  = xyp_r >>> F;
  assign yxh  = yxp_r >>> F;

  awcg_div #(.FRAC_BITS(FRAC_BITS)) u_div_yx (
    .clk (clk),
    .en  (en),
    .num (rt.yx_num),
    .den (rt.yx_den),
    .zoom(cmd.scale_x),
    .quo (yxz)
  );

  awcg_div #(.FRAC_BITS(FRAC_BITS)) u_div_xy (
    .clk (clk),
    .en  (en),
    .num (rt.xy_num),
    .den (rt.xy_den),
    .zoom(cmd.scale_y),
    .quo (xyz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-1:1], cmd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[1] <= '{ident: cmd.ident, offset_x: cmd.offset_x, origin_y: cmd.origin_y};
      for (int k = 2; k <= DEPTH; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      a_r[1]  <= a_in;
      zx_r[1] <= cmd.scale_x;
      zy_r[1] <= cmd.scale_y;
      for (int k = 2; k <= 7; k++) begin
        a_r[k] <= a_r[k-1];
      end
      for (int k = 2; k <= 10; k++) begin
        zx_r[k] <= zx_r[k-1];
        zy_r[k] <= zy_r[k-1];
      end

      sq_r     <= PW'(a_in) * PW'(a_in);
      n1_r     <= n1_w[AW-1:0];
      c_r[2]   <= ONE_A - n1_w[AW-1:0];
      p3_r     <= PW'(n1_r) * PW'(a_r[2]);
      c_r[3]   <= c_r[2];
      m4_r     <= (UW+K3+1)'(u4) * (UW+K3+1)'(M3);
      c_r[4]   <= c_r[3];
      n2_r     <= n2_w;
      s_r[5]   <= a_r[4] - n2_w;
      c_r[5]   <= c_r[4];
      p6_r     <= PW'(n2_r) * PW'(a_r[5]);
      s_r[6]   <= s_r[5];
      c_r[6]   <= c_r[5];
      n3_r     <= n3_w[AW-1:0];
      s_r[7]   <= s_r[6];
      c_r[7]   <= c_r[6] + n3_w[AW-1:0];
      p8_r     <= PW'(n3_r) * PW'(a_r[7]);
      s_r[8]   <= s_r[7];
      c_r[8]   <= c_r[7];
      m9_r     <= (UW+K5+1)'(u9) * (UW+K5+1)'(M5);
      s_r[9]   <= s_r[8];
      c_r[9]   <= c_r[8];
      s_r[10]  <= s_r[9] + n4_w;
      c_r[10]  <= c_r[9];
      for (int k = 11; k <= DL; k++) begin
        s_r[k] <= s_r[k-1];
      end

      xxp_r    <= (AW+33)'(c_r[10]) * (AW+33)'($signed({1'b0, zx_r[10]}));
      yyp_r    <= (AW+33)'(c_r[10]) * (AW+33)'($signed({1'b0, zy_r[10]}));
      xx_r[12] <= sat32(64'(xxh));
      yy_r[12] <= sat32(64'(yyh));
      for (int k = 13; k <= DEPTH - 1; k++) begin
        xx_r[k] <= xx_r[k-1];
        yy_r[k] <= yy_r[k-1];
      end

      xyp_r <= (AW+32)'(s_r[DL]) * (AW+32)'(xyz);
      yxp_r <= (AW+32)'(s_r[DL]) * (AW+32)'(yxz);

      if (ctl_r[DEPTH-1].ident) begin
        xx_o_r <= ONE_O;
        xy_o_r <= '0;
        yx_o_r <= '0;
        yy_o_r <= ONE_O;
      end else begin
        xx_o_r <= xx_r[DEPTH-1];
        xy_o_r <= sat32(64'(xyh));
        yx_o_r <= sat32(-64'(yxh));
        yy_o_r <= yy_r[DEPTH-1];
      end
      ox_o_r <= ctl_r[DEPTH-1].offset_x;
      oy_o_r <= ctl_r[DEPTH-1].origin_y;
    end
  end

  assign out_chan.valid    = v_r[DEPTH];
  assign out_chan.xx_step  = xx_o_r;
  assign out_chan.xy_step  = xy_o_r;
  assign out_chan.yx_step  = yx_o_r;
  assign out_chan.yy_step  = yy_o_r;
  assign out_chan.origin_x = ox_o_r;
  assign out_chan.origin_y = oy_o_r;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the affine warp coefficient generator.
module tb;
  import awcg_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 240;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic        compensate;
    logic [31:0] angle;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] scale_x;
    logic [31:0] scale_y;
  } warp_req_t;

  typedef struct {
    logic [31:0] xx, xy, yx, yy, ox, oy;
  } warp_coef_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  awcg_in_if in_chan();
  awcg_out_if out_chan();

  affine_warp_coefficient_gen dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  warp_req_t  pending_q[$];
  warp_coef_t coef_q[$];
  logic [15:0] geo_w = 16'd720, geo_h = 16'd288;
  logic        geo_prog = 1'b0;
  int  errors = 0;
  int  accepted = 0;
  bit  tx_gaps = 1'b1, rx_gaps = 1'b1, choke = 1'b0;
  int  tx_wait = 0, rx_wait = 0;

  function automatic longint fdiv(longint v, longint d);
    longint q;
    q = v / d;
    if (v % d < 0) q--;
    return q;
  endfunction

  function automatic longint rdiv(longint v, longint d);
    return fdiv(2 * v + d, 2 * d);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint aspect(longint num, longint den, longint zoom);
    if (den * zoom == 0) return 64'sd2147483647;
    return clip32(rdiv(num * ONE * ONE, den * zoom));
  endfunction

  function automatic warp_coef_t predict_warp(warp_req_t r);
    warp_coef_t o;
    longint a, lim, n, c, s, zx, zy, yxz, xyz;
    a = longint'(signed'(r.angle));
    zx = longint'(r.scale_x);
    zy = longint'(r.scale_y);
    if (!r.compensate) begin
      o = '{32'(ONE), 0, 0, 32'(ONE), 0, 0};
      return o;
    end
    lim = geo_prog ? rdiv(4 * ONE, 10) : ONE / 2;
    if (a > lim) a = lim;
    else if (a < -lim) a = -lim;
    s = a;
    n = rdiv(a * a, 2 * ONE);
    c = ONE - n;
    n = rdiv(n * a, 3 * ONE);
    s -= n;
    n = rdiv(n * a, 4 * ONE);
    c += n;
    n = rdiv(n * a, 5 * ONE);
    s += n;
    if (geo_w == 16'd720 && geo_h == 16'd288) begin
      yxz = aspect(8, 15, zx); xyz = aspect(15, 8, zy);
    end else if (geo_w == 16'd720) begin
      yxz = aspect(4, 9, zx); xyz = aspect(9, 4, zy);
    end else if (geo_prog) begin
      yxz = aspect(1, 1, zx); xyz = aspect(1, 1, zy);
    end else begin
      yxz = aspect(1, 2, zx); xyz = aspect(2, 1, zy);
    end
    o.xx = 32'(clip32(rdiv(c * zx, ONE)));
    o.yy = 32'(clip32(rdiv(c * zy, ONE)));
    o.xy = 32'(clip32(fdiv(s * xyz, ONE)));
    o.yx = 32'(clip32(-fdiv(s * yxz, ONE)));
    o.ox = r.offset_x;
    o.oy = geo_prog ? r.offset_y : 32'(clip32(rdiv(longint'(signed'(r.offset_y)), 2)));
    return o;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic int draw_gap(bit on);
    return on ? ((($urandom_range(0, 3) == 0)) ? $urandom_range(0, 13) : 0) : 0;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.compensate <= 1'b0;
      in_chan.angle <= '0;
      in_chan.offset_x <= '0;
      in_chan.offset_y <= '0;
      in_chan.scale_x <= '0;
      in_chan.scale_y <= '0;
      tx_wait = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        coef_q.push_back(predict_warp(pending_q.pop_front()));
        accepted++;
        tx_wait = draw_gap(tx_gaps);
      end
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_chan.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_chan.valid <= 1'b1;
          in_chan.compensate <= pending_q[0].compensate;
          in_chan.angle <= pending_q[0].angle;
          in_chan.offset_x <= pending_q[0].offset_x;
          in_chan.offset_y <= pending_q[0].offset_y;
          in_chan.scale_x <= pending_q[0].scale_x;
          in_chan.scale_y <= pending_q[0].scale_y;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    warp_coef_t w;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (coef_q.size() == 0) begin
          errors++;
          $display("unexpected transfer at %0t", $realtime);
        end else begin
          w = coef_q.pop_front();
          if (out_chan.xx_step !== w.xx) note_mismatch("xx_step", out_chan.xx_step, w.xx);
          if (out_chan.xy_step !== w.xy) note_mismatch("xy_step", out_chan.xy_step, w.xy);
          if (out_chan.yx_step !== w.yx) note_mismatch("yx_step", out_chan.yx_step, w.yx);
          if (out_chan.yy_step !== w.yy) note_mismatch("yy_step", out_chan.yy_step, w.yy);
          if (out_chan.origin_x !== w.ox) note_mismatch("origin_x", out_chan.origin_x, w.ox);
          if (out_chan.origin_y !== w.oy) note_mismatch("origin_y", out_chan.origin_y, w.oy);
        end
        rx_wait = draw_gap(rx_gaps);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !choke;
      end
    end
  end

  // long receiver stall so the pipeline backs up
  initial begin
    wait (accepted > 300);
    @(posedge clk);
    choke <= 1'b1;
    repeat (400) @(posedge clk);
    choke <= 1'b0;
  end

  initial begin
    #(8 * 2000000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  geo_w = val;
      CFG_FRAME_HEIGHT: geo_h = val;
      CFG_PROGRESSIVE:  geo_prog = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_req(logic comp, logic [31:0] ang, logic [31:0] ox, logic [31:0] oy,
                           logic [31:0] sx, logic [31:0] sy);
    warp_req_t r;
    r = '{comp, ang, ox, oy, sx, sy};
    pending_q.push_back(r);
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return $urandom_range(0, 3);
      default: return $urandom_range(32'h4000, 32'h40000);
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      default: return 32'($signed($urandom_range(0, 80000)) - 40000);
    endcase
  endfunction

  task automatic settle();
    wait (pending_q.size() == 0 && coef_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] geo_list[8][3];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at reset geometry
    queue_req(0, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    queue_req(1, 0, 0, 0, 32'h10000, 32'h10000);
    queue_req(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    queue_req(1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    queue_req(1, 32'h00008000, 1, 32'hffffffff, 32'h10000, 0);
    queue_req(1, 32'hffff8000, 32'hffffffff, 32'hfffffffd, 0, 32'h10000);
    queue_req(1, 32'h00008001, 5, 3, 1, 1);
    queue_req(1, 32'hffff7fff, 5, 32'h7ffffffd, 2, 32'h80000000);
    queue_req(1, 32'h00006666, 7, 32'h80000001, 32'h8000, 32'h20000);
    queue_req(1, 32'hffff999a, 7, 1, 32'h20000, 32'h8000);
    queue_req(1, 1, 0, 32'hfffffffe, 32'h7fffffff, 32'h80000000);
    queue_req(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    settle();

    geo_list = '{'{720, 288, 0}, '{720, 480, 0}, '{720, 288, 1}, '{720, 0, 1},
                 '{1920, 1080, 1}, '{1920, 1080, 0}, '{0, 0, 0}, '{65535, 65535, 1}};
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_FRAME_WIDTH, geo_list[p][0]);
      write_reg(CFG_FRAME_HEIGHT, geo_list[p][1]);
      write_reg(CFG_PROGRESSIVE, geo_list[p][2]);
      if (p == 3) write_reg(CFG_UNUSED, 16'hffff);
      tx_gaps = (p % 3) != 1;
      rx_gaps = (p % 4) != 2;
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_req($urandom_range(0, 9) != 0, rand_angle(), $urandom(), $urandom(),
                  rand_scale(), rand_scale());
      if (p == 4) begin
        // sender pauses mid phase until all results are back
        wait (pending_q.size() == 0 && coef_q.size() == 0);
        for (int i = 0; i < 20; i++)
          queue_req(1, rand_angle(), $urandom(), $urandom(), rand_scale(), rand_scale());
      end
      settle();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/awcg_pkg.sv
sv/awcg_if.sv
sv/awcg_front.sv
sv/awcg_fifo.sv
sv/awcg_div.sv
sv/awcg_back.sv
sv/affine_warp_coefficient_gen.sv
tb/tb.sv
